@@ src/ctd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ctd_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam logic [15:0] EXPIRY_RST = 16'd100;
  localparam logic [4:0]  RM_MAX     = 5'd31;

  localparam logic       FUNC_OBSERVE = 1'b0;
  localparam logic       FUNC_TICK    = 1'b1;
  localparam logic [1:0] KIND_OTHER   = 2'd0;

  typedef enum logic [2:0] {
    V_NOT_RELEVANT = 3'd0,
    V_NEW          = 3'd1,
    V_CHANGED      = 3'd2,
    V_UNCHANGED    = 3'd3,
    V_TABLE_FULL   = 3'd4,
    V_TICK_DONE    = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic        func;
    logic [1:0]  kind;
    logic [31:0] key;
    logic        flag;
  } req_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [4:0]  removed;
  } res_t;

  typedef struct packed {
    logic [31:0] pos;
    logic        flag;
    logic [15:0] age;
  } ent_t;

  localparam int unsigned ENT_W = $bits(ent_t);

endpackage

`default_nettype wire

@@ src/ctd_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ctd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/ctd_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ctd_engine
  import ctd_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [15:0] expiry,
  input  wire logic        req_vld,
  input  wire req_t        req,
  output logic             req_rdy,
  output logic             res_vld,
  output res_t             res,
  input  wire logic        res_rdy
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = IDX_W + 1;

  state_t state_r, state_nxt;

  req_t               req_r;
  res_t               res_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               chk_vld_r;
  logic [IDX_W-1:0]   chk_idx_r;
  logic [ENTRIES-1:0] valid_r;
  logic               hit_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic               hit_flag_r;
  logic               free_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic [4:0]         rm_cnt_r;

  logic             rd_en;
  ent_t             rd_ent;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  ent_t             ram_wdata;
  logic             entry_v;
  logic [15:0]      age_inc;
  logic             expire;
  logic             chk_last;
  logic             is_tick;
  verdict_t         upd_verdict;

  ctd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .re    (rd_en),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (rd_ent),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata)
  );

  assign is_tick  = (req_r.func == FUNC_TICK);
  assign rd_en    = (state_r == ST_SCAN) && (cnt_r < CNT_W'(ENTRIES));
  assign chk_last = chk_vld_r && (chk_idx_r == IDX_W'(ENTRIES - 1));
  assign entry_v  = valid_r[chk_idx_r];
  assign age_inc  = (rd_ent.age == 16'hFFFF) ? rd_ent.age : rd_ent.age + 16'd1;
  assign expire   = (age_inc >= expiry);

  // ram write port and observe decision
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = chk_idx_r;
    ram_wdata   = '{pos: rd_ent.pos, flag: rd_ent.flag, age: age_inc};
    upd_verdict = V_TICK_DONE;
    if (state_r == ST_SCAN) begin
      if (chk_vld_r && is_tick && entry_v && !expire) begin
        ram_we = 1'b1;
      end
    end else if (state_r == ST_UPDATE && !is_tick) begin
      ram_wdata = '{pos: req_r.key, flag: req_r.flag, age: 16'd0};
      if (hit_r) begin
        ram_waddr = hit_idx_r;
        if (hit_flag_r != req_r.flag) begin
          ram_we      = 1'b1;
          upd_verdict = V_CHANGED;
        end else begin
          upd_verdict = V_UNCHANGED;
        end
      end else if (free_r) begin
        ram_we      = 1'b1;
        ram_waddr   = free_idx_r;
        upd_verdict = V_NEW;
      end else begin
        upd_verdict = V_TABLE_FULL;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    req_rdy   = (state_r == ST_IDLE);
    res_vld   = (state_r == ST_RESP);
    res       = res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (req_vld) begin
          if (req.func == FUNC_OBSERVE && req.kind == KIND_OTHER) begin
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (chk_last) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (res_rdy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      chk_vld_r <= 1'b0;
      valid_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= rd_en;
      if (state_r == ST_SCAN && chk_vld_r && is_tick && entry_v && expire) begin
        valid_r[chk_idx_r] <= 1'b0;
      end
      if (state_r == ST_UPDATE && !is_tick && !hit_r && free_r) begin
        valid_r[free_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= cnt_r[IDX_W-1:0];
    if (state_r == ST_IDLE) begin
      req_r    <= req;
      cnt_r    <= '0;
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
      rm_cnt_r <= '0;
      res_r    <= '{verdict: V_NOT_RELEVANT, removed: 5'd0};
    end else begin
      if (rd_en) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (state_r == ST_SCAN && chk_vld_r) begin
        if (is_tick) begin
          if (entry_v && expire && rm_cnt_r != RM_MAX) begin
            rm_cnt_r <= rm_cnt_r + 5'd1;
          end
        end else begin
          if (entry_v && rd_ent.pos == req_r.key && !hit_r) begin
            hit_r      <= 1'b1;
            hit_idx_r  <= chk_idx_r;
            hit_flag_r <= rd_ent.flag;
          end
          if (!entry_v && !free_r) begin
            free_r     <= 1'b1;
            free_idx_r <= chk_idx_r;
          end
        end
      end
      if (state_r == ST_UPDATE) begin
        res_r.verdict <= upd_verdict;
        res_r.removed <= is_tick ? rm_cnt_r : 5'd0;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/change_detect_table_with_aging.sv @@
// relevant observe or tick: scans every entry ram slot, one read per cycle, then updates
// and answers through the registered out_tvalid; an observe of kind other skips the scan
// a new input beat is taken only once the previous result has left the engine (in_tready
// is high only in idle)
// reset: synchronous active low rst_n clears all valid bits, expiry_ticks returns to 100
`timescale 1ns / 1ps
`default_nettype none

module change_detect_table_with_aging
  import ctd_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,  // obj_kind, pos_x, pos_y, obj_flag, zero pad
  input  wire logic        in_tuser,  // func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata, // verdict, removed_count
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  logic [15:0] expiry_ticks_r;
  logic        out_vld_r;
  logic [7:0]  out_data_r;

  req_t req;
  logic req_rdy;
  logic res_vld;
  res_t res;
  logic res_rdy;

  assign req = '{func: in_tuser, kind: in_tdata[1:0],
                 key: {in_tdata[17:2], in_tdata[33:18]}, flag: in_tdata[34]};

  assign res_rdy    = !out_vld_r || out_tready;
  assign in_tready  = req_rdy;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  ctd_engine #(
    .ENTRIES (ENTRIES)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .expiry  (expiry_ticks_r),
    .req_vld (in_tvalid),
    .req     (req),
    .req_rdy (req_rdy),
    .res_vld (res_vld),
    .res     (res),
    .res_rdy (res_rdy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_ticks_r <= EXPIRY_RST;
      out_vld_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        expiry_ticks_r <= cfg_wdata;
      end
      if (res_rdy) begin
        out_vld_r <= res_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_rdy && res_vld) begin
      out_data_r <= {res.removed, res.verdict};
    end
  end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import ctd_pkg::*;

  localparam logic [1:0] KIND_ALARM    = 2'd1;
  localparam logic [1:0] KIND_DOOR     = 2'd2;
  localparam logic [1:0] KIND_FOUNTAIN = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 600;
  localparam int SETTLE_CYCLES  = ENTRIES_DEF + 8;

  typedef struct packed {
    logic        func;
    logic [1:0]  kind;
    logic [15:0] px;
    logic [15:0] py;
    logic        flag;
  } obs_beat_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_we     = 1'b0;
  logic [15:0] cfg_wdata  = '0;

  change_detect_table_with_aging DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // table tracker
  logic        tbl_valid [ENTRIES_DEF];
  logic [31:0] tbl_key   [ENTRIES_DEF];
  logic        tbl_flag  [ENTRIES_DEF];
  logic [15:0] tbl_age   [ENTRIES_DEF];
  logic [15:0] expiry_model = EXPIRY_RST;

  obs_beat_t pending_beats[$];
  res_t      expected_verdicts[$];
  int        mismatches = 0;

  task automatic predict_verdict(input obs_beat_t b, output res_t r);
    logic [31:0] key;
    int hit;
    int free_slot;
    int removed;
    key = {b.px, b.py};
    hit = -1;
    free_slot = -1;
    removed = 0;
    r.removed = 5'd0;
    if (b.func == FUNC_TICK) begin
      for (int i = 0; i < ENTRIES_DEF; i++) begin
        if (tbl_valid[i]) begin
          if (tbl_age[i] != 16'hFFFF) tbl_age[i] = tbl_age[i] + 16'd1;
          if (tbl_age[i] >= expiry_model) begin
            tbl_valid[i] = 1'b0;
            removed++;
          end
        end
      end
      r.verdict = V_TICK_DONE;
      r.removed = (removed > 31) ? RM_MAX : 5'(removed);
    end else if (b.kind == KIND_OTHER) begin
      r.verdict = V_NOT_RELEVANT;
    end else begin
      for (int i = 0; i < ENTRIES_DEF; i++) begin
        if (hit < 0 && tbl_valid[i] && tbl_key[i] == key) hit = i;
        if (free_slot < 0 && !tbl_valid[i]) free_slot = i;
      end
      if (hit >= 0) begin
        if (tbl_flag[hit] != b.flag) begin
          tbl_flag[hit] = b.flag;
          tbl_age[hit]  = 16'd0;
          r.verdict = V_CHANGED;
        end else begin
          r.verdict = V_UNCHANGED;
        end
      end else if (free_slot < 0) begin
        r.verdict = V_TABLE_FULL;
      end else begin
        tbl_valid[free_slot] = 1'b1;
        tbl_key[free_slot]   = key;
        tbl_flag[free_slot]  = b.flag;
        tbl_age[free_slot]   = 16'd0;
        r.verdict = V_NEW;
      end
    end
  endtask

  // sender: bursts with random gaps
  obs_beat_t cur_beat;
  int gap_left   = 0;
  int burst_left = 1;

  always @(posedge clk) begin
    res_t r;
    if (!rst_n) begin
      in_tvalid    <= 1'b0;
      expiry_model = EXPIRY_RST;
      for (int i = 0; i < ENTRIES_DEF; i++) tbl_valid[i] = 1'b0;
    end else begin
      if (cfg_we) expiry_model = cfg_wdata;
      if (in_tvalid && in_tready) begin
        predict_verdict(cur_beat, r);
        expected_verdicts.insert(expected_verdicts.size(), r);
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          cur_beat = pending_beats.pop_front();
          in_tdata  <= {5'b0, cur_beat.flag, cur_beat.py, cur_beat.px, cur_beat.kind};
          in_tuser  <= cur_beat.func;
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern plus one long hold-off
  int  rx_mode      = 0;
  int  mode_left    = 0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;
  int  inputs_seen  = 0;
  int  rx_phase     = 0;

  always @(posedge clk) begin
    res_t exp_r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) inputs_seen++;
      if (out_tvalid && out_tready) begin
        if (expected_verdicts.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result beat: verdict %0d removed %0d",
                     out_tdata[2:0], out_tdata[7:3]);
          mismatches++;
        end else begin
          exp_r = expected_verdicts.pop_front();
          if (out_tdata[2:0] !== exp_r.verdict || out_tdata[7:3] !== exp_r.removed) begin
            if (mismatches < 10)
              $display("mismatch: expected verdict %0d removed %0d, got verdict %0d removed %0d",
                       exp_r.verdict, exp_r.removed, out_tdata[2:0], out_tdata[7:3]);
            mismatches++;
          end
        end
      end
      if (!hold_done && inputs_seen >= 300) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      rx_phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= $urandom_range(0, 1);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ((rx_phase % 5) < 2);
        endcase
      end
    end
  end

  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_run = 0;
      else idle_run++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic queue_beat(input logic func, input logic [1:0] kind,
                            input logic [15:0] px, input logic [15:0] py,
                            input logic flag);
    obs_beat_t b;
    b.func = func;
    b.kind = kind;
    b.px   = px;
    b.py   = py;
    b.flag = flag;
    pending_beats.insert(pending_beats.size(), b);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_beats.size() > 0 || in_tvalid || expected_verdicts.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_expiry(input logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [15:0] pool_x [24];
    logic [15:0] pool_y [24];
    logic [15:0] expiry_val;
    logic [1:0]  kind;
    logic [15:0] px;
    logic [15:0] py;
    int pool_n;
    int sel;
    int idx;

    // default expiry: irrelevant kind, inserts at the extremes, change, no change
    queue_beat(FUNC_OBSERVE, KIND_OTHER, 16'h8000, 16'h7FFF, 1'b1);
    queue_beat(FUNC_OBSERVE, KIND_ALARM, 16'h8000, 16'h8000, 1'b0);
    queue_beat(FUNC_OBSERVE, KIND_DOOR, 16'h7FFF, 16'h7FFF, 1'b1);
    queue_beat(FUNC_OBSERVE, KIND_FOUNTAIN, 16'h0000, 16'h0000, 1'b0);
    queue_beat(FUNC_OBSERVE, KIND_ALARM, 16'h8000, 16'h8000, 1'b1);
    queue_beat(FUNC_OBSERVE, KIND_FOUNTAIN, 16'h8000, 16'h8000, 1'b1);
    queue_beat(FUNC_TICK, KIND_FOUNTAIN, 16'hFFFF, 16'hFFFF, 1'b1);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // short expiry forgets everything after two ticks
    write_expiry(16'd2);
    queue_beat(FUNC_TICK, KIND_OTHER, 16'h0000, 16'h0000, 1'b0);
    queue_beat(FUNC_TICK, KIND_DOOR, 16'h5A5A, 16'hA5A5, 1'b1);
    wait_idle();

    // fill the table, overflow it, then clear it all with expiry zero
    write_expiry(16'd0);
    for (int i = 0; i < ENTRIES_DEF; i++)
      queue_beat(FUNC_OBSERVE, 2'(1 + i % 3), 16'(i * 4099), 16'h8000 ^ 16'(i), i[0]);
    queue_beat(FUNC_OBSERVE, KIND_DOOR, 16'h1234, 16'h4321, 1'b0);
    queue_beat(FUNC_OBSERVE, KIND_ALARM, 16'h0000, 16'h8000, 1'b1);
    queue_beat(FUNC_TICK, KIND_ALARM, 16'h0000, 16'h0000, 1'b0);
    wait_idle();

    for (int p = 0; p < 12; p++) begin
      case (p)
        0: expiry_val = 16'hFFFF;
        1: expiry_val = 16'd1;
        2: expiry_val = 16'd0;
        3: expiry_val = 16'($urandom_range(1, 65535));
        default: expiry_val = 16'($urandom_range(2, 12));
      endcase
      write_expiry(expiry_val);
      pool_n = (p % 2 == 1) ? 6 : 24;
      for (int k = 0; k < 24; k++) begin
        pool_x[k] = 16'($urandom);
        pool_y[k] = 16'($urandom);
      end
      for (int n = 0; n < 150; n++) begin
        sel = $urandom_range(0, 99);
        if ($urandom_range(0, 4) == 0) begin
          px = 16'($urandom);
          py = 16'($urandom);
        end else begin
          idx = $urandom_range(0, pool_n - 1);
          px = pool_x[idx];
          py = pool_y[idx];
        end
        if (sel < 12) begin
          queue_beat(FUNC_TICK, 2'($urandom_range(0, 3)), px, py, 1'($urandom));
        end else begin
          kind = (sel < 22) ? KIND_OTHER : 2'($urandom_range(1, 3));
          queue_beat(FUNC_OBSERVE, kind, px, py, 1'($urandom));
        end
      end
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
